>>> src/adjacency_list_table_macros.svh
// ----------------------------------------------------------------------------
// adjacency_list_table assertion macros
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_LIST_TABLE_MACROS_SVH
`define ADJACENCY_LIST_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ALT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ALT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ALT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ALT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/alt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_pkg
// Shared field widths, request codes, FSM states and the command/status
// structs between the adjacency list controller and datapath.
// ----------------------------------------------------------------------------
package alt_pkg;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int VTX_W     = 8;
    localparam int DEG_OUT_W = 5;
    localparam int EDGE_W    = 13;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CHECK  = 2'd3
    } req_type_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DISPATCH,
        ST_POP_WAIT,
        ST_SCAN,
        ST_LAST_RD,
        ST_MOVE,
        ST_RESP
    } alt_state_t;

    // Neighbor store address source: offset added to the vertex base
    typedef enum logic [1:0] {
        ADDR_APPEND,
        ADDR_LAST,
        ADDR_SCAN,
        ADDR_MATCH
    } addr_sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load;      // capture request, start degree read
        logic      deg_latch; // take degree read data
        logic      st_rd;     // neighbor store read
        logic      st_wr;     // neighbor store write
        addr_sel_t addr_sel;
        logic      top_upd;   // fold vertex/neighbor into top vertex
        logic      inc;       // degree and edge count up, ok
        logic      dec;       // degree and edge count down, ok
        logic      pop;       // capture removed neighbor
        logic      scan_clr;
        logic      match_set;
        logic      set_ok;
        logic      resp;      // load output register
    } alt_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        req_type_t req;
        logic      v_ok;
        logic      nb_ok;
        logic      deg_zero;
        logic      deg_full;
        logic      scan_more;
        logic      cmp_pend;
        logic      cmp_hit;
        logic      out_free;
    } alt_sts_t;

endpackage
`default_nettype wire

>>> src/alt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_req_if
// Request channel: valid/ready handshake with request type, vertex, neighbor.
// ----------------------------------------------------------------------------
interface alt_req_if import alt_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] neighbor;

    modport source (output valid, output req_type, output vertex, output neighbor,
                    input ready);
    modport sink   (input valid, input req_type, input vertex, input neighbor,
                    output ready);

endinterface
`default_nettype wire

>>> src/alt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_rsp_if
// Response channel: valid/ready handshake with one result per request.
// ----------------------------------------------------------------------------
interface alt_rsp_if import alt_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [VTX_W-1:0]     neighbor_out;
    logic [DEG_OUT_W-1:0] degree;
    logic [EDGE_W-1:0]    edge_total;
    logic [VTX_W-1:0]     top_vertex;

    modport source (output valid, output ok, output neighbor_out, output degree,
                    output edge_total, output top_vertex, input ready);
    modport sink   (input valid, input ok, input neighbor_out, input degree,
                    input edge_total, input top_vertex, output ready);

endinterface
`default_nettype wire

>>> src/adjacency_list_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_list_table
// Directed graph store with fixed-capacity neighbor lists per vertex.
// ----------------------------------------------------------------------------
// One request is in flight at a time; each gives one response, which sits in
// an output register so the next request is taken while it waits. A remove
// that hits reads the last entry of the list and writes it into the matched
// slot. The scan is paced by the single-port neighbor store, read one slot
// per cycle with the compare of each slot in the cycle after its read. Degree
// counts reset to zero at once through per-vertex valid bits; no clearing
// pass is needed after reset. A full list rejects an add with ok low, and a
// vertex at or above VERTICES is ignored with ok and degree both zero.
// ----------------------------------------------------------------------------
`include "adjacency_list_table_macros.svh"

module adjacency_list_table import alt_pkg::*;
#(
    parameter int VERTICES   = 256,
    parameter int MAX_DEGREE = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    alt_req_if.sink   req,
    alt_rsp_if.source rsp
);

    alt_cmd_t cmd;
    alt_sts_t sts;

    // Sequencer
    alt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Storage and arithmetic
    alt_dp #(
        .VERTICES   (VERTICES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_type (req.req_type),
        .vertex   (req.vertex),
        .neighbor (req.neighbor),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp)
    );

    // One request at a time: a transfer closes the request port
    `ALT_ASSERT_NXT(a_one_in_flight, clk, rst_n, req.valid && req.ready, !req.ready, "request taken while busy")

    // Single-port store: never read and written together
    `ALT_ASSERT_IMP(a_store_port, clk, rst_n, cmd.st_wr, !cmd.st_rd, "store read and write collide")

    // Scan never reads past the degree
    `ALT_ASSERT_IMP(a_scan_bound, clk, rst_n, cmd.st_rd && (cmd.addr_sel == ADDR_SCAN), sts.scan_more, "scan read beyond list")

    // Result only loaded into a free output register
    `ALT_ASSERT_IMP(a_resp_free, clk, rst_n, cmd.resp, sts.out_free, "response overwrote pending result")

endmodule
`default_nettype wire

>>> src/alt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_ctrl
// Request sequencer: degree lookup, append, pop, slot scan with swap-remove,
// and handoff to the output register.
// ----------------------------------------------------------------------------
module alt_ctrl import alt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output alt_cmd_t      cmd,
    input  wire alt_sts_t sts
);

    alt_state_t state_reg;
    alt_state_t state_next;
    logic       hit;

    assign hit = sts.cmp_pend && sts.cmp_hit;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (!sts.v_ok)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    unique case (sts.req)
                        REQ_ADD:
                        begin
                            state_next = ST_RESP;
                        end
                        REQ_POP:
                        begin
                            state_next = sts.deg_zero ? ST_RESP : ST_POP_WAIT;
                        end
                        REQ_REMOVE, REQ_CHECK:
                        begin
                            state_next = sts.deg_zero ? ST_RESP : ST_SCAN;
                        end
                    endcase
                end
            end
            ST_POP_WAIT:
            begin
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = (sts.req == REQ_CHECK) ? ST_RESP : ST_LAST_RD;
                end
                else if (sts.scan_more || sts.cmp_pend)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_LAST_RD:
            begin
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_LOOKUP:
            begin
                cmd.deg_latch = 1'b1;
            end
            ST_DISPATCH:
            begin
                if (sts.v_ok)
                begin
                    unique case (sts.req)
                        REQ_ADD:
                        begin
                            if (sts.nb_ok)
                            begin
                                cmd.top_upd = 1'b1;
                                if (!sts.deg_full)
                                begin
                                    cmd.st_wr    = 1'b1;
                                    cmd.addr_sel = ADDR_APPEND;
                                    cmd.inc      = 1'b1;
                                end
                            end
                        end
                        REQ_POP:
                        begin
                            if (!sts.deg_zero)
                            begin
                                cmd.st_rd    = 1'b1;
                                cmd.addr_sel = ADDR_LAST;
                            end
                        end
                        REQ_REMOVE, REQ_CHECK:
                        begin
                            cmd.scan_clr = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_WAIT:
            begin
                cmd.pop = 1'b1;
                cmd.dec = 1'b1;
            end
            ST_SCAN:
            begin
                // compare of the previous read wins over issuing the next one
                priority if (hit)
                begin
                    if (sts.req == REQ_CHECK)
                    begin
                        cmd.set_ok = 1'b1;
                    end
                    else
                    begin
                        cmd.match_set = 1'b1;
                    end
                end
                else if (sts.scan_more)
                begin
                    cmd.st_rd    = 1'b1;
                    cmd.addr_sel = ADDR_SCAN;
                end
            end
            ST_LAST_RD:
            begin
                cmd.st_rd    = 1'b1;
                cmd.addr_sel = ADDR_LAST;
            end
            ST_MOVE:
            begin
                cmd.st_wr    = 1'b1;
                cmd.addr_sel = ADDR_MATCH;
                cmd.dec      = 1'b1;
            end
            ST_RESP:
            begin
                cmd.resp = sts.out_free;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/alt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alt_dp
// Datapath: degree memory with valid bits, single-port neighbor store,
// scan compare pipeline, edge/top counters and the output register.
// ----------------------------------------------------------------------------
module alt_dp import alt_pkg::*;
#(
    parameter int VERTICES   = 256,
    parameter int MAX_DEGREE = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire logic [VTX_W-1:0] vertex,
    input  wire logic [VTX_W-1:0] neighbor,
    input  wire alt_cmd_t         cmd,
    output alt_sts_t              sts,
    alt_rsp_if.source             rsp
);

    // Only vertices that the 8-bit field can name get storage
    localparam int DEG_ENTRIES = (VERTICES < 2**VTX_W) ? VERTICES : 2**VTX_W;
    localparam int DEG_IDX_W   = $clog2(DEG_ENTRIES);
    localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
    localparam int ST_DEPTH    = DEG_ENTRIES * MAX_DEGREE;
    localparam int ADDR_W      = $clog2(ST_DEPTH);

    // Memories
    logic [DEG_W-1:0] deg_mem [DEG_ENTRIES];
    logic [VTX_W-1:0] nb_mem  [ST_DEPTH];

    logic [DEG_ENTRIES-1:0] deg_vld_reg;
    logic [DEG_W-1:0]       deg_rd_reg;
    logic                   deg_rd_vld_reg;

    // Request context
    req_type_t        req_reg;
    logic [VTX_W-1:0] vertex_reg;
    logic [VTX_W-1:0] nb_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [DEG_W-1:0] deg_reg;
    logic [DEG_W-1:0] deg_new;
    logic [DEG_W-1:0] scan_idx_reg;
    logic [DEG_W-1:0] cmp_idx_reg;
    logic [DEG_W-1:0] match_idx_reg;
    logic             pend_reg;
    logic [VTX_W-1:0] rd_data_reg;
    logic [VTX_W-1:0] nb_out_reg;
    logic             ok_reg;
    logic [EDGE_W-1:0] edge_reg;
    logic [VTX_W-1:0] top_reg;
    logic [VTX_W-1:0] top_next;

    // Output register
    logic                 out_valid_reg;
    logic                 out_ok_reg;
    logic [VTX_W-1:0]     out_nb_reg;
    logic [DEG_OUT_W-1:0] out_deg_reg;
    logic [EDGE_W-1:0]    out_edge_reg;
    logic [VTX_W-1:0]     out_top_reg;

    logic [DEG_W-1:0]     st_off;
    logic [ADDR_W-1:0]    st_addr;
    logic [VTX_W-1:0]     st_wdata;
    logic [DEG_IDX_W-1:0] vidx;
    logic                 scan_rd;

    assign vidx    = vertex_reg[DEG_IDX_W-1:0];
    assign scan_rd = cmd.st_rd && (cmd.addr_sel == ADDR_SCAN);
    assign deg_new = cmd.inc ? (deg_reg + DEG_W'(1)) : (deg_reg - DEG_W'(1));

    // Store address: vertex base plus slot offset
    always_comb
    begin
        st_off = deg_reg;
        unique case (cmd.addr_sel)
            ADDR_APPEND: st_off = deg_reg;
            ADDR_LAST:   st_off = deg_reg - DEG_W'(1);
            ADDR_SCAN:   st_off = scan_idx_reg;
            ADDR_MATCH:  st_off = match_idx_reg;
        endcase
        st_addr  = base_reg + ADDR_W'(st_off);
        st_wdata = (cmd.addr_sel == ADDR_MATCH) ? rd_data_reg : nb_reg;
    end

    // Highest vertex after an add
    always_comb
    begin
        top_next = top_reg;
        if (vertex_reg > top_next)
        begin
            top_next = vertex_reg;
        end
        if (nb_reg > top_next)
        begin
            top_next = nb_reg;
        end
    end

    // Neighbor store: one access per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.st_wr)
        begin
            nb_mem[st_addr] <= st_wdata;
        end
        if (cmd.st_rd)
        begin
            rd_data_reg <= nb_mem[st_addr];
        end
    end

    // Degree memory
    always_ff @(posedge clk)
    begin
        if (cmd.inc || cmd.dec)
        begin
            deg_mem[vidx] <= deg_new;
        end
        if (cmd.load)
        begin
            deg_rd_reg <= deg_mem[vertex[DEG_IDX_W-1:0]];
        end
    end

    // Degree valid bits: an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_vld_reg    <= '0;
            deg_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.inc || cmd.dec)
            begin
                deg_vld_reg[vidx] <= 1'b1;
            end
            if (cmd.load)
            begin
                deg_rd_vld_reg <= deg_vld_reg[vertex[DEG_IDX_W-1:0]];
            end
        end
    end

    // Request context and scan pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type_t'(req_type);
            vertex_reg <= vertex;
            nb_reg     <= neighbor;
            base_reg   <= ADDR_W'(vertex[DEG_IDX_W-1:0]) * ADDR_W'(MAX_DEGREE);
            ok_reg     <= 1'b0;
            nb_out_reg <= '0;
        end
        if (cmd.deg_latch)
        begin
            deg_reg <= (sts.v_ok && deg_rd_vld_reg) ? deg_rd_reg : '0;
        end
        if (cmd.inc || cmd.dec)
        begin
            deg_reg <= deg_new;
            ok_reg  <= 1'b1;
        end
        if (cmd.set_ok)
        begin
            ok_reg <= 1'b1;
        end
        if (cmd.pop)
        begin
            nb_out_reg <= rd_data_reg;
        end
        if (cmd.scan_clr)
        begin
            scan_idx_reg <= '0;
        end
        if (scan_rd)
        begin
            scan_idx_reg <= scan_idx_reg + DEG_W'(1);
            cmp_idx_reg  <= scan_idx_reg;
        end
        if (cmd.match_set)
        begin
            match_idx_reg <= cmp_idx_reg;
        end
    end

    // Counters and compare-pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            edge_reg <= '0;
            top_reg  <= '0;
        end
        else
        begin
            pend_reg <= scan_rd;
            if (cmd.inc)
            begin
                edge_reg <= edge_reg + EDGE_W'(1);
            end
            else if (cmd.dec)
            begin
                edge_reg <= edge_reg - EDGE_W'(1);
            end
            if (cmd.top_upd)
            begin
                top_reg <= top_next;
            end
        end
    end

    // Output register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.resp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            out_ok_reg   <= ok_reg;
            out_nb_reg   <= nb_out_reg;
            out_deg_reg  <= DEG_OUT_W'(deg_reg);
            out_edge_reg <= edge_reg;
            out_top_reg  <= top_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.neighbor_out = out_nb_reg;
    assign rsp.degree       = out_deg_reg;
    assign rsp.edge_total   = out_edge_reg;
    assign rsp.top_vertex   = out_top_reg;

    // Status
    assign sts.req       = req_reg;
    assign sts.v_ok      = 32'(vertex_reg) < VERTICES;
    assign sts.nb_ok     = 32'(nb_reg) < VERTICES;
    assign sts.deg_zero  = (deg_reg == '0);
    assign sts.deg_full  = (deg_reg >= DEG_W'(MAX_DEGREE));
    assign sts.scan_more = (scan_idx_reg < deg_reg);
    assign sts.cmp_pend  = pend_reg;
    assign sts.cmp_hit   = (rd_data_reg == nb_reg);
    assign sts.out_free  = !out_valid_reg || rsp.ready;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adjacency list graph store. Requests go in on
// the request channel; every accepted request is run through a local graph
// model that predicts the single response. Responses are checked in order,
// field by field, against those predictions. Directed cases cover empty and
// full lists, duplicate neighbors and top-vertex tracking, then random
// traffic grows and shrinks lists on a small set of busy vertices.
// ----------------------------------------------------------------------------
module testbench;
    import alt_pkg::*;

    localparam int VERTEX_COUNT = 256;
    localparam int LIST_CAP     = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 36;
    localparam int MAX_REPORTS  = 10;

    // One response as the block should return it
    typedef struct packed {
        logic                 ok;
        logic [VTX_W-1:0]     nb_out;
        logic [DEG_OUT_W-1:0] degree;
        logic [EDGE_W-1:0]    edge_total;
        logic [VTX_W-1:0]     top;
    } graph_reply_t;

    logic clk;
    logic rst_n;
    bit   steady;     // no idling on either side while set
    int   err_count;

    alt_req_if req_ch ();
    alt_rsp_if rsp_ch ();

    adjacency_list_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the graph
    logic [VTX_W-1:0]  adj_slot [VERTEX_COUNT][LIST_CAP];
    int unsigned       list_len [VERTEX_COUNT];
    logic [EDGE_W-1:0] edge_sum;
    logic [VTX_W-1:0]  top_seen;

    graph_reply_t predicted_replies [$];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one request to the local graph and return the reply it gives.
    // Every 8-bit vertex and neighbor is in range at 256 vertices.
    function automatic graph_reply_t graph_update(req_type_t op, logic [VTX_W-1:0] v,
                                                  logic [VTX_W-1:0] n);
        graph_reply_t r;
        int unsigned  d;
        int unsigned  i;
        r = '0;
        d = list_len[v];
        case (op)
            REQ_ADD:
            begin
                // top vertex follows every add, even onto a full list
                if (v > top_seen) top_seen = v;
                if (n > top_seen) top_seen = n;
                if (d < LIST_CAP)
                begin
                    adj_slot[v][d] = n;
                    d++;
                    edge_sum++;
                    r.ok = 1'b1;
                end
            end
            REQ_POP:
            begin
                if (d > 0)
                begin
                    d--;
                    r.nb_out = adj_slot[v][d];
                    edge_sum--;
                    r.ok = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                // first match gets the last entry moved into its slot
                for (i = 0; i < d; i++)
                begin
                    if (adj_slot[v][i] == n)
                    begin
                        adj_slot[v][i] = adj_slot[v][d-1];
                        d--;
                        edge_sum--;
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            default:
            begin
                for (i = 0; i < d; i++)
                begin
                    if (adj_slot[v][i] == n)
                    begin
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
        endcase
        list_len[v]  = d;
        r.degree     = d[DEG_OUT_W-1:0];
        r.edge_total = edge_sum;
        r.top        = top_seen;
        return r;
    endfunction

    // Drive one request; called at a falling edge, returns at a falling edge
    task automatic issue_request(req_type_t op, logic [VTX_W-1:0] v, logic [VTX_W-1:0] n);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.vertex   <= v;
        req_ch.neighbor <= n;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted_replies.push_back(graph_update(op, v, n));
        @(negedge clk);
    endtask

    task automatic note_failure(string what, graph_reply_t want, graph_reply_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t %s: expected ok=%0d nb=%0d deg=%0d edges=%0d top=%0d, got ok=%0d nb=%0d deg=%0d edges=%0d top=%0d",
                     $time, what, want.ok, want.nb_out, want.degree, want.edge_total,
                     want.top, got.ok, got.nb_out, got.degree, got.edge_total, got.top);
    endtask

    // Empty lists: every lookup and removal fails
    task automatic test_empty_lists();
        issue_request(REQ_CHECK, 8'd3, 8'd0);
        issue_request(REQ_POP, 8'd3, 8'd0);
        issue_request(REQ_REMOVE, 8'd3, 8'd0);
    endtask

    // Adds, duplicates, swap-remove and pop on short lists
    task automatic test_add_and_remove();
        issue_request(REQ_ADD, 8'd0, 8'd0);
        issue_request(REQ_ADD, 8'd7, 8'd3);      // top taken from vertex
        issue_request(REQ_ADD, 8'd0, 8'd255);    // top taken from neighbor
        issue_request(REQ_ADD, 8'd0, 8'd0);      // duplicate edge
        issue_request(REQ_CHECK, 8'd0, 8'd255);
        issue_request(REQ_REMOVE, 8'd0, 8'd0);   // hit in slot 0, last moves in
        issue_request(REQ_POP, 8'd0, 8'd0);
    endtask

    // Fill one list to capacity, then an add must be refused
    task automatic test_full_list();
        int k;
        for (k = 0; k < LIST_CAP; k++)
            issue_request(REQ_ADD, 8'd255, (k % 2 == 0) ? 8'hAA : 8'h55);
        issue_request(REQ_ADD, 8'd255, 8'd1);
    endtask

    // Random traffic on a few busy vertices, alternating grow and shrink phases
    task automatic test_random_traffic();
        logic [VTX_W-1:0] hot_vtx [6];
        logic [VTX_W-1:0] nb_pool [8];
        logic [VTX_W-1:0] v;
        logic [VTX_W-1:0] n;
        req_type_t        op;
        int unsigned      roll;
        int unsigned      d;
        bit               grow;
        int               k;
        for (k = 0; k < 6; k++)
            hot_vtx[k] = VTX_W'($urandom_range(0, 255));
        for (k = 0; k < 8; k++)
            nb_pool[k] = VTX_W'($urandom_range(0, 255));
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = (k >= 250 && k < 370);
            grow   = ((k / 100) % 2) == 0;
            if ($urandom_range(0, 99) < 85)
                v = hot_vtx[$urandom_range(0, 5)];
            else
                v = VTX_W'($urandom_range(0, 255));
            d    = list_len[v];
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 55 : 15))
                op = REQ_ADD;
            else if (roll < (grow ? 70 : 45))
                op = REQ_POP;
            else if (roll < (grow ? 85 : 75))
                op = REQ_REMOVE;
            else
                op = REQ_CHECK;
            // lookups mostly aim at a stored neighbor
            if (op != REQ_ADD && d > 0 && $urandom_range(0, 99) < 70)
                n = adj_slot[v][$urandom_range(0, d - 1)];
            else if ($urandom_range(0, 99) < 40)
                n = nb_pool[$urandom_range(0, 7)];
            else
                n = VTX_W'($urandom_range(0, 255));
            issue_request(op, v, n);
        end
        steady = 1'b0;
    endtask

    // Response sink ready
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Response check against the oldest prediction
    always @(posedge clk)
    begin
        graph_reply_t got;
        graph_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.ok         = rsp_ch.ok;
            got.nb_out     = rsp_ch.neighbor_out;
            got.degree     = rsp_ch.degree;
            got.edge_total = rsp_ch.edge_total;
            got.top        = rsp_ch.top_vertex;
            if (predicted_replies.size() == 0)
                note_failure("unexpected response", '0, got);
            else
            begin
                want = predicted_replies.pop_front();
                if (got.ok !== want.ok || got.nb_out !== want.nb_out ||
                    got.degree !== want.degree || got.edge_total !== want.edge_total ||
                    got.top !== want.top)
                    note_failure("response mismatch", want, got);
            end
        end
    end

    // Watchdog: too long without any transfer
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial
    begin
        int k;
        rst_n           = 1'b0;
        steady          = 1'b0;
        err_count       = 0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_ADD;
        req_ch.vertex   = '0;
        req_ch.neighbor = '0;
        for (k = 0; k < VERTEX_COUNT; k++)
            list_len[k] = 0;
        edge_sum = '0;
        top_seen = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_lists();
        test_add_and_remove();
        test_full_list();
        test_random_traffic();
        req_ch.valid <= 1'b0;

        // drain, then allow for a late or extra response
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> adjacency_list_table.f
+incdir+src
src/alt_pkg.sv
src/alt_req_if.sv
src/alt_rsp_if.sv
src/alt_ctrl.sv
src/alt_dp.sv
src/adjacency_list_table.sv
tb/testbench.sv
